[sv/mdwm_pkg.sv]
package mdwm_pkg;

  localparam int WINDOW_CYCLES_DEF = 100 * 16000;
  localparam int SCALE_DEF         = 256;

  localparam int NUM_MOTORS = 3;
  localparam int MOT_W      = $clog2(NUM_MOTORS);
  localparam int FLAG_W     = NUM_MOTORS + 1;
  localparam int SEL_W      = $clog2(FLAG_W);
  localparam int DUTY_W     = 10;
  localparam int QDEPTH     = 4;

  localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

  localparam logic [1:0] KIND_MOTOR = 2'd0;
  localparam logic [1:0] KIND_MASK  = 2'd1;
  localparam logic [1:0] KIND_TIME  = 2'd2;

  localparam logic REP_DUTY = 1'b0;
  localparam logic REP_MASK = 1'b1;

  typedef enum logic [1:0] {
    OP_MOTOR,
    OP_MASK,
    OP_TIME
  } op_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [31:0] now;
  } in_word_t;

  typedef struct packed {
    logic              report_kind;
    logic [1:0]        motor_index;
    logic [1:0]        direction;
    logic [DUTY_W-1:0] duty;
    logic [2:0]        sensor_mask;
    logic              last;
  } out_word_t;

  typedef struct packed {
    op_e         op;
    logic [7:0]  value;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DUTY_W-1:0] quot;
  } div_rsp_t;

  // drive fields: motor 0 in 7:6, motor 1 in 3:2, motor 2 in 1:0
  function automatic logic [1:0] drive_field(logic [7:0] b, logic [MOT_W-1:0] idx);
    logic [1:0] f;
    unique case (idx)
      MOT_W'(0): f = b[7:6];
      MOT_W'(1): f = b[3:2];
      default:   f = b[1:0];
    endcase
    return f;
  endfunction

endpackage

[sv/motor_duty_window_monitor_top.sv]
// channel | handshake               | word
// --------+-------------------------+----------------------------------------------
// in      | in_valid_i / in_ready_o | in_word_i: kind, value, now
// out     | out_valid_o/out_ready_i | out_word_o: report_kind, motor_index,
//         |                         |   direction, duty, sensor_mask, last
//
// Motor, mask and non-closing time words retire one per cycle from a 4-deep queue
// while the back end is idle. A window close holds the back end while the
// three-stage reciprocal divider runs for each motor and the reports are emitted.
// The front keeps accepting until the queue is full; a stalled output holds the back.
// Reset clears all state to zero except the queue's storage; no clearing pass.
module motor_duty_window_monitor_top
  import mdwm_pkg::*;
#(
  parameter int WINDOW_CYCLES = WINDOW_CYCLES_DEF,
  parameter int SCALE         = SCALE_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int DIVISOR = (WINDOW_CYCLES / SCALE == 0) ? 1 : WINDOW_CYCLES / SCALE;

  logic     q_valid, q_ready;
  cmd_t     q_cmd;
  div_req_t div_req;
  div_rsp_t div_rsp;

  mdwm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_cmd_o    (q_cmd)
  );

  mdwm_div #(
    .DIVISOR (DIVISOR)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  mdwm_back #(
    .WINDOW_CYCLES (WINDOW_CYCLES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_cmd_i     (q_cmd),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

[sv/mdwm_front.sv]
module mdwm_front
  import mdwm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  output logic     q_valid_o,
  input  logic     q_ready_i,
  output cmd_t     q_cmd_o
);

  localparam int PTR_W = $clog2(QDEPTH);

  cmd_t             fifo_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;
  logic             keep;
  op_e              op;
  logic             push, pop;

  // classify: unused kind is taken and dropped
  always_comb begin
    keep = 1'b1;
    op   = OP_TIME;
    unique case (in_word_i.kind)
      KIND_MOTOR: op = OP_MOTOR;
      KIND_MASK:  op = OP_MASK;
      KIND_TIME:  op = OP_TIME;
      default:    keep = 1'b0;
    endcase
  end

  assign in_ready_o = (count_q != (PTR_W + 1)'(QDEPTH));
  assign push       = in_valid_i && in_ready_o && keep;
  assign q_valid_o  = (count_q != '0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_cmd_o    = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + (PTR_W + 1)'(1);
    end else if (pop && !push) begin
      count_d = count_q - (PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{op: op, value: in_word_i.value, now: in_word_i.now};
    end
  end

endmodule

[sv/mdwm_div.sv]
module mdwm_div
  import mdwm_pkg::*;
#(
  parameter int DIVISOR = WINDOW_CYCLES_DEF / SCALE_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int DW = $clog2(DIVISOR + 1);
  localparam int CW = (DW + DUTY_W > 32) ? DW + DUTY_W : 32;
  localparam logic [CW-1:0] LIMIT = CW'(DIVISOR) << DUTY_W;
  localparam logic [31:0]   DIV   = 32'(DIVISOR);
  // floor((2^32 - 1) / DIVISOR): the estimate is exact or one low
  localparam logic [31:0]   RECIP = 32'(64'hffff_ffff / DIVISOR);

  logic              v1_q, v2_q, done_q;
  logic              sat1_q, sat2_q;
  logic [31:0]       x1_q;
  logic [63:0]       prod_q;
  logic [DUTY_W-1:0] est_q, quot_q;
  logic [31:0]       rem_q;
  logic [DUTY_W-1:0] est;
  logic [31:0]       rem;

  assign est = prod_q[32 +: DUTY_W];
  assign rem = x1_q - DIV * 32'(est);

  // reciprocal multiply, remainder, one correction step; saturation is detected up front
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
      sat1_q <= 1'b0;
      sat2_q <= 1'b0;
      x1_q   <= '0;
      prod_q <= '0;
      est_q  <= '0;
      rem_q  <= '0;
      quot_q <= '0;
    end else begin
      v1_q   <= req_i.start;
      v2_q   <= v1_q;
      done_q <= v2_q;
      if (req_i.start) begin
        sat1_q <= (CW'(req_i.dividend) >= LIMIT);
        x1_q   <= req_i.dividend;
        prod_q <= 64'(req_i.dividend) * 64'(RECIP);
      end
      if (v1_q) begin
        sat2_q <= sat1_q;
        est_q  <= est;
        rem_q  <= rem;
      end
      if (v2_q) begin
        quot_q <= sat2_q ? DUTY_MAX : est_q + DUTY_W'(rem_q >= DIV);
      end
    end
  end

  assign rsp_o = '{done: done_q, quot: quot_q};

endmodule

[sv/mdwm_back.sv]
module mdwm_back
  import mdwm_pkg::*;
#(
  parameter int WINDOW_CYCLES = WINDOW_CYCLES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  output logic      q_ready_o,
  input  cmd_t      q_cmd_i,
  output div_req_t  div_req_o,
  input  div_rsp_t  div_rsp_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam logic [31:0] WIN = 32'(WINDOW_CYCLES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [7:0]        drive_q, drive_d;
  logic [31:0]       last_t_q, last_t_d;
  logic [31:0]       deadline_q, deadline_d;
  logic [31:0]       on_time_q [NUM_MOTORS];
  logic [31:0]       on_time_d [NUM_MOTORS];
  logic [1:0]        win_dir_q [NUM_MOTORS];
  logic [1:0]        win_dir_d [NUM_MOTORS];
  logic [DUTY_W-1:0] rep_duty_q [NUM_MOTORS];
  logic [DUTY_W-1:0] rep_duty_d [NUM_MOTORS];
  logic [1:0]        rep_dir_q [NUM_MOTORS];
  logic [1:0]        rep_dir_d [NUM_MOTORS];
  logic [7:0]        cur_mask_q, cur_mask_d;
  logic [7:0]        pend_mask_q, pend_mask_d;
  logic [7:0]        rep_mask_q, rep_mask_d;
  logic [MOT_W-1:0]  mot_q, mot_d;
  logic [FLAG_W-1:0] flags_q, flags_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_word_q, out_word_d;

  logic [31:0]       elapsed, diff;
  logic [1:0]        fld;
  logic [SEL_W-1:0]  sel;
  logic              found;
  logic [FLAG_W-1:0] rest;

  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int i = 0; i < FLAG_W; i++) begin
      if (flags_q[i] && !found) begin
        sel   = SEL_W'(i);
        found = 1'b1;
      end
    end
    rest = flags_q & ~(FLAG_W'(1) << sel);
  end

  always_comb begin
    state_d     = state_q;
    drive_d     = drive_q;
    last_t_d    = last_t_q;
    deadline_d  = deadline_q;
    on_time_d   = on_time_q;
    win_dir_d   = win_dir_q;
    rep_duty_d  = rep_duty_q;
    rep_dir_d   = rep_dir_q;
    cur_mask_d  = cur_mask_q;
    pend_mask_d = pend_mask_q;
    rep_mask_d  = rep_mask_q;
    mot_d       = mot_q;
    flags_d     = flags_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q && !out_ready_i;
    q_ready_o   = 1'b0;
    div_req_o   = '{start: 1'b0, dividend: on_time_q[mot_q]};
    elapsed     = q_cmd_i.now - last_t_q;
    diff        = q_cmd_i.now - deadline_q;
    fld         = '0;

    unique case (state_q)
      ST_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          if (q_cmd_i.op != OP_MASK) begin
            for (int i = 0; i < NUM_MOTORS; i++) begin
              fld = drive_field(drive_q, MOT_W'(i));
              if (fld != '0) begin
                on_time_d[i] = on_time_q[i] + elapsed;
                win_dir_d[i] = fld;
              end
            end
            last_t_d = q_cmd_i.now;
          end
          unique case (q_cmd_i.op)
            OP_MOTOR: drive_d = q_cmd_i.value;
            OP_MASK: begin
              cur_mask_d  = q_cmd_i.value;
              pend_mask_d = pend_mask_q | q_cmd_i.value;
            end
            OP_TIME: begin
              if (!diff[31]) begin
                deadline_d            = deadline_q + WIN;
                flags_d               = '0;
                flags_d[NUM_MOTORS]   = (pend_mask_q != rep_mask_q);
                rep_mask_d            = pend_mask_q;
                pend_mask_d           = cur_mask_q;
                mot_d                 = '0;
                state_d               = ST_DIV_START;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV_START: begin
        div_req_o.start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp_i.done) begin
          flags_d[mot_q]    = (div_rsp_i.quot != rep_duty_q[mot_q])
                              || (win_dir_q[mot_q] != rep_dir_q[mot_q]);
          rep_duty_d[mot_q] = div_rsp_i.quot;
          rep_dir_d[mot_q]  = win_dir_q[mot_q];
          on_time_d[mot_q]  = '0;
          win_dir_d[mot_q]  = '0;
          if (mot_q == MOT_W'(NUM_MOTORS - 1)) begin
            state_d = ST_EMIT;
          end else begin
            mot_d   = mot_q + MOT_W'(1);
            state_d = ST_DIV_START;
          end
        end
      end
      ST_EMIT: begin
        if (flags_q == '0) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          flags_d     = rest;
          if (sel == SEL_W'(NUM_MOTORS)) begin
            out_word_d = '{report_kind: REP_MASK, motor_index: '0, direction: '0,
                           duty: '0, sensor_mask: rep_mask_q[2:0], last: (rest == '0)};
          end else begin
            out_word_d = '{report_kind: REP_DUTY, motor_index: 2'(sel),
                           direction: rep_dir_q[MOT_W'(sel)],
                           duty: rep_duty_q[MOT_W'(sel)], sensor_mask: '0,
                           last: (rest == '0)};
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      drive_q     <= '0;
      last_t_q    <= '0;
      deadline_q  <= '0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        on_time_q[i]  <= '0;
        win_dir_q[i]  <= '0;
        rep_duty_q[i] <= '0;
        rep_dir_q[i]  <= '0;
      end
      cur_mask_q  <= '0;
      pend_mask_q <= '0;
      rep_mask_q  <= '0;
      mot_q       <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      state_q     <= state_d;
      drive_q     <= drive_d;
      last_t_q    <= last_t_d;
      deadline_q  <= deadline_d;
      on_time_q   <= on_time_d;
      win_dir_q   <= win_dir_d;
      rep_duty_q  <= rep_duty_d;
      rep_dir_q   <= rep_dir_d;
      cur_mask_q  <= cur_mask_d;
      pend_mask_q <= pend_mask_d;
      rep_mask_q  <= rep_mask_d;
      mot_q       <= mot_d;
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[verif/testbench.sv]
module testbench;
  import mdwm_pkg::*;

  localparam logic [1:0]  KIND_UNUSED  = 2'd3;
  localparam logic [31:0] DUTY_DIV     = (WINDOW_CYCLES_DEF / SCALE_DEF == 0) ?
                                         32'd1 : 32'(WINDOW_CYCLES_DEF / SCALE_DEF);
  localparam int          RANDOM_WORDS = 286;
  localparam int          DRAIN_CYCLES = 400;

  typedef out_word_t [3:0] report_set_t;

  typedef struct packed {
    in_word_t    word;
    logic        typed;
    logic [2:0]  n_reports;
    report_set_t reports;
  } stim_row_t;

  logic      clk_i;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  // predicted block state
  logic [7:0]        p_drive;
  logic [31:0]       p_last_time;
  logic [31:0]       p_deadline;
  logic [31:0]       p_on_time  [NUM_MOTORS];
  logic [1:0]        p_win_dir  [NUM_MOTORS];
  logic [DUTY_W-1:0] p_rep_duty [NUM_MOTORS];
  logic [1:0]        p_rep_dir  [NUM_MOTORS];
  logic [7:0]        p_cur_mask;
  logic [7:0]        p_pend_mask;
  logic [7:0]        p_rep_mask;

  out_word_t   step_reports [4];
  int          step_count;
  out_word_t   reports_due [$];
  out_word_t   due_report;
  int          burst_left = 0;
  int          stall_left = 0;
  int          calm_left = 0;
  logic [31:0] cycle_now;
  bit          failed = 1'b0;

  motor_duty_window_monitor_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void track_monitor_word(in_word_t w);
    logic [31:0]       elapsed;
    logic [31:0]       lag;
    logic [31:0]       quot;
    logic [1:0]        f;
    logic [1:0]        dir;
    logic [DUTY_W-1:0] duty;
    out_word_t         r;
    step_count = 0;
    if (w.kind == KIND_MOTOR || w.kind == KIND_TIME) begin
      elapsed = w.now - p_last_time;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        f = 2'(p_drive >> ((i == 0) ? 6 : (i == 1) ? 2 : 0));
        if (f != 2'd0) begin
          p_on_time[i] += elapsed;
          p_win_dir[i] = f;
        end
      end
      p_last_time = w.now;
    end
    if (w.kind == KIND_MOTOR) begin
      p_drive = w.value;
    end else if (w.kind == KIND_MASK) begin
      p_cur_mask = w.value;
      p_pend_mask |= w.value;
    end else if (w.kind == KIND_TIME) begin
      lag = w.now - p_deadline;
      if (!lag[31]) begin
        p_deadline += 32'(WINDOW_CYCLES_DEF);
        for (int i = 0; i < NUM_MOTORS; i++) begin
          quot = p_on_time[i] / DUTY_DIV;
          duty = (quot > 32'(DUTY_MAX)) ? DUTY_MAX : quot[DUTY_W-1:0];
          dir  = p_win_dir[i];
          if (dir != p_rep_dir[i] || duty != p_rep_duty[i]) begin
            r = '0;
            r.report_kind = REP_DUTY;
            r.motor_index = 2'(i);
            r.direction   = dir;
            r.duty        = duty;
            step_reports[step_count] = r;
            step_count++;
            p_rep_dir[i]  = dir;
            p_rep_duty[i] = duty;
          end
          p_on_time[i] = '0;
          p_win_dir[i] = '0;
        end
        if (p_pend_mask != p_rep_mask) begin
          r = '0;
          r.report_kind = REP_MASK;
          r.sensor_mask = p_pend_mask[2:0];
          step_reports[step_count] = r;
          step_count++;
          p_rep_mask = p_pend_mask;
        end
        p_pend_mask = p_cur_mask;
        if (step_count > 0) step_reports[step_count-1].last = 1'b1;
      end
    end
  endfunction

  function automatic out_word_t duty_rep(int idx, logic [1:0] dir, int duty, bit last);
    out_word_t r;
    r = '0;
    r.report_kind = REP_DUTY;
    r.motor_index = 2'(idx);
    r.direction   = dir;
    r.duty        = DUTY_W'(duty);
    r.last        = last;
    return r;
  endfunction

  function automatic report_set_t reports_of(out_word_t a, out_word_t b = '0,
                                             out_word_t c = '0);
    report_set_t s;
    s    = '0;
    s[0] = a;
    s[1] = b;
    s[2] = c;
    return s;
  endfunction

  function automatic stim_row_t stim_row(logic [1:0] kind, logic [7:0] value,
                                         logic [31:0] now, int n = -1,
                                         report_set_t reports = '0);
    stim_row_t s;
    s.word.kind  = kind;
    s.word.value = value;
    s.word.now   = now;
    s.typed      = (n >= 0);
    s.n_reports  = 3'((n < 0) ? 0 : n);
    s.reports    = reports;
    return s;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endfunction

  task automatic send_word(input stim_row_t s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) :
                                                 $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= s.word;
    do @(posedge clk_i); while (!in_ready);
    track_monitor_word(s.word);
    if (s.typed) begin
      for (int i = 0; i < s.n_reports; i++) reports_due.push_back(s.reports[i]);
    end else begin
      for (int i = 0; i < step_count; i++) reports_due.push_back(step_reports[i]);
    end
  endtask

  // output stalls: random short stalls, with occasional calm stretches
  always @(posedge clk_i) begin
    if (calm_left > 0) begin
      calm_left--;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 99) < 3) begin
      calm_left = $urandom_range(50, 300);
    end else if ($urandom_range(0, 99) < 30) begin
      stall_left = $urandom_range(1, 12);
    end
    out_ready <= (stall_left == 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (reports_due.size() == 0) begin
        $error("report word with nothing due: %p", out_word);
        failed = 1'b1;
      end else begin
        due_report = reports_due.pop_front();
        check_field("report_kind", due_report.report_kind, out_word.report_kind);
        check_field("motor_index", due_report.motor_index, out_word.motor_index);
        check_field("direction", due_report.direction, out_word.direction);
        check_field("duty", due_report.duty, out_word.duty);
        check_field("sensor_mask", due_report.sensor_mask, out_word.sensor_mask);
        check_field("last", due_report.last, out_word.last);
      end
    end
  end

  initial begin
    stim_row_t plan [$];
    in_word_t  w;
    int        n_words;
    int        pick;

    p_drive     = '0;
    p_last_time = '0;
    p_deadline  = '0;
    p_cur_mask  = '0;
    p_pend_mask = '0;
    p_rep_mask  = '0;
    for (int i = 0; i < NUM_MOTORS; i++) begin
      p_on_time[i]  = '0;
      p_win_dir[i]  = '0;
      p_rep_duty[i] = '0;
      p_rep_dir[i]  = '0;
    end

    // window closes at zero, nothing changed yet
    plan.push_back(stim_row(KIND_TIME,   8'h00, 32'd0, 0));
    plan.push_back(stim_row(KIND_MASK,   8'hff, 32'hffff_ffff, 0));
    plan.push_back(stim_row(KIND_TIME,   8'h00, 32'd1, 0));
    plan.push_back(stim_row(KIND_TIME,   8'h00, 32'd1_600_000, 1,
                            reports_of('{report_kind: REP_MASK, motor_index: 2'd0,
                                         direction: 2'd0, duty: '0,
                                         sensor_mask: 3'd7, last: 1'b1})));
    plan.push_back(stim_row(KIND_MOTOR,  8'hff, 32'd1_600_000, 0));
    // all motors on for a full window
    plan.push_back(stim_row(KIND_TIME,   8'h00, 32'd3_200_000, 3,
                            reports_of(duty_rep(0, 2'd3, 256, 1'b0),
                                       duty_rep(1, 2'd3, 256, 1'b0),
                                       duty_rep(2, 2'd3, 256, 1'b1))));
    plan.push_back(stim_row(KIND_MOTOR,  8'h40, 32'd3_200_000, 0));
    // long on-time saturates; idle motors keep the direction marked at zero elapsed
    plan.push_back(stim_row(KIND_TIME,   8'h00, 32'd13_200_000, 3,
                            reports_of(duty_rep(0, 2'd1, 1023, 1'b0),
                                       duty_rep(1, 2'd3, 0, 1'b0),
                                       duty_rep(2, 2'd3, 0, 1'b1))));
    plan.push_back(stim_row(KIND_TIME,   8'hff, 32'd13_200_000));
    plan.push_back(stim_row(KIND_MASK,   8'h05, 32'd13_200_000));
    plan.push_back(stim_row(KIND_MOTOR,  8'h80, 32'd14_000_000));
    plan.push_back(stim_row(KIND_MOTOR,  8'h0c, 32'd14_400_000));
    plan.push_back(stim_row(KIND_MOTOR,  8'h02, 32'd14_800_000));
    plan.push_back(stim_row(KIND_MOTOR,  8'h33, 32'd15_000_000));
    plan.push_back(stim_row(KIND_TIME,   8'h00, 32'd16_000_000));
    plan.push_back(stim_row(KIND_UNUSED, 8'hff, 32'hffff_ffff));
    plan.push_back(stim_row(KIND_MOTOR,  8'h00, 32'd17_000_000));
    plan.push_back(stim_row(KIND_MASK,   8'h00, 32'd17_000_000));
    // counter wrap and the sign boundary of the deadline distance
    plan.push_back(stim_row(KIND_TIME,   8'h00, 32'hffff_fff0));
    plan.push_back(stim_row(KIND_TIME,   8'h00, 32'h0000_0010));
    plan.push_back(stim_row(KIND_TIME,   8'h00, 32'h7fff_ffff));
    plan.push_back(stim_row(KIND_TIME,   8'h00, 32'h8000_0000));
    plan.push_back(stim_row(KIND_MOTOR,  8'haa, 32'h8000_0000));
    plan.push_back(stim_row(KIND_TIME,   8'h55, 32'h8030_0000));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) send_word(plan[i]);

    cycle_now = 32'h8030_0000;
    n_words   = 0;
    while (n_words < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        w.kind  = KIND_UNUSED;
        w.value = 8'($urandom);
        w.now   = $urandom;
      end else if (pick < 8) begin
        w.kind  = 2'($urandom_range(0, 2));
        w.value = 8'($urandom);
        w.now   = $urandom;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      cycle_now += $urandom_range(0, 400_000);
        else if (pick < 99) cycle_now += $urandom_range(400_000, 3_200_000);
        else                cycle_now += $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 35)      w.kind = KIND_MOTOR;
        else if (pick < 50) w.kind = KIND_MASK;
        else                w.kind = KIND_TIME;
        w.value = 8'($urandom);
        w.now   = cycle_now;
      end
      send_word(stim_row(w.kind, w.value, w.now));
      n_words++;
    end

    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
